// ===== design/hrlp_pkg.sv =====
// hrlp_pkg: shared constants, codes and types of the request line parser
// no dependencies
`default_nettype none
package hrlp_pkg;
	localparam int unsigned LEN_W = 13;
	localparam logic [LEN_W-1:0] MAX_LINE = 13'd8191;
	localparam int unsigned MAX_METHOD = 7;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_BAD     = 2'd1;
	localparam logic [1:0] STATUS_VERSION = 2'd2;

	typedef enum logic [3:0] {
		ST_METHOD, ST_URL_GAP, ST_SCHEME, ST_HOST, ST_PORT, ST_PATH,
		ST_QUERY, ST_VER_GAP, ST_VER_PREFIX, ST_VER_MAJOR, ST_VER_MINOR
	} stage_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [2:0]       method;
		logic             version_minor;
		logic [LEN_W-1:0] host_offset;
		logic [LEN_W-1:0] host_len;
		logic [LEN_W-1:0] port_offset;
		logic [LEN_W-1:0] port_len;
		logic [LEN_W-1:0] path_offset;
		logic [LEN_W-1:0] path_len;
		logic [LEN_W-1:0] ext_len;
		logic [LEN_W-1:0] query_offset;
		logic [LEN_W-1:0] query_len;
	} result_t;

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_alnum(input logic [7:0] b);
		return is_digit(b) || (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == 8'h20 || b == 8'h09;
	endfunction

	function automatic logic path_char_ok(input logic [7:0] b);
		logic r;
		case (b) inside
			8'h7B, 8'h7D, 8'h7C, 8'h5C, 8'h5E, 8'h7E, 8'h5B, 8'h5D,
			8'h27, 8'h3C, 8'h3E, 8'h22, 8'h20: r = 1'b0;
			default: r = !(b <= 8'h1F || b >= 8'h7F);
		endcase
		return r;
	endfunction

	function automatic logic query_char_ok(input logic [7:0] b);
		return b == 8'h3D || b == 8'h26 || b == 8'h25 || is_alnum(b);
	endfunction

	// decimal accumulate, saturating at 15
	function automatic logic [3:0] sat_acc(input logic [3:0] acc, input logic [7:0] b);
		logic [7:0] v;
		v = {4'd0, acc} * 8'd10 + (b - 8'h30);
		return (v > 8'd15) ? 4'd15 : v[3:0];
	endfunction

	// lower-case letter of "http/" at a given place
	function automatic logic [7:0] ver_char(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0: c = 8'h68;
			3'd1: c = 8'h74;
			3'd2: c = 8'h74;
			3'd3: c = 8'h70;
			3'd4: c = 8'h2F;
			default: c = 8'h00;
		endcase
		return c;
	endfunction
endpackage
`default_nettype wire

// ===== design/hrlp_stream_if.sv =====
// hrlp_stream_if: valid/ready channel carrying one payload item
// no dependencies
`default_nettype none
interface hrlp_stream_if #(parameter type T = logic [7:0]);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/hrlp_method_match.sv =====
// hrlp_method_match: matches collected method bytes against the eight names
// depends on hrlp_pkg
`default_nettype none
module hrlp_method_match (
	input  wire logic [55:0] chars,
	input  wire logic [2:0]  count,
	output logic             hit,
	output logic [2:0]       code
);
	import hrlp_pkg::*;

	// names packed low byte first, zero padded
	always_comb begin
		hit  = 1'b1;
		code = 3'd0;
		case (chars)
			56'h0000000054_4547:       code = 3'd0;
			56'h0000000054_5550:       code = 3'd1;
			56'h00000054_534F50:       code = 3'd2;
			56'h00000044_414548:       code = 3'd3;
			56'h000045_43415254:       code = 3'd4;
			56'h0045_5445_4C45_44:     code = 3'd5;
			56'h53_4E_4F_49_54_50_4F:  code = 3'd6;
			56'h54_43_45_4E_4E_4F_43:  code = 3'd7;
			default:                   hit = 1'b0;
		endcase
		if (count == 3'd0 || count > 3'(MAX_METHOD))
			hit = 1'b0;
	end
endmodule
`default_nettype wire

// ===== design/http_request_line_parser_unit.sv =====
// http_request_line_parser_unit: top level of the request line parser
// depends on hrlp_pkg, hrlp_stream_if, hrlp_method_match
//
// One byte is taken every cycle while the skid is empty. Each byte is
// classified and the line state updated in the cycle it is accepted; a
// result (at CR LF or the first error) lands in an output register with a
// one-entry skid behind it, so input keeps flowing while one result waits.
// Status 1 is a bad request, 2 an unsupported version; fields other than
// status are zero on error.
`default_nettype none
module http_request_line_parser_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [hrlp_pkg::LEN_W-1:0]  cfg_wdata,
	hrlp_stream_if.sink                      req,
	hrlp_stream_if.source                    res
);
	import hrlp_pkg::*;

	logic [LEN_W-1:0] max_len_q;
	stage_t           stage_q;
	logic [LEN_W-1:0] pos_q;
	logic [55:0]      mchars_q;
	logic [2:0]       mcount_q, mcode_q, sub_q;
	logic [3:0]       major_q, minor_q;
	logic [LEN_W-1:0] host_off_q, host_len_q, port_off_q, port_len_q;
	logic [LEN_W-1:0] path_off_q, path_len_q, ext_q, query_off_q, query_len_q;
	logic             saw_cr_q, discard_q;

	result_t          out_q, skid_q;
	logic             out_vld_q, skid_vld_q;

	logic       m_hit;
	logic [2:0] m_code;
	hrlp_method_match u_match (.chars(mchars_q), .count(mcount_q), .hit(m_hit), .code(m_code));

	logic [7:0] b;
	logic       take;
	logic [LEN_W-1:0] limit, pos1;
	assign b     = req.data;
	assign req.ready = !skid_vld_q;
	assign take  = req.valid && req.ready;
	assign limit = (max_len_q < MAX_LINE) ? max_len_q : MAX_LINE;
	assign pos1  = pos_q + 1'b1;

	// per-byte decision
	logic       emit, err, restart, nxt_discard;
	logic [1:0] st;
	logic [7:0] lc;
	assign lc = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;

	always_comb begin
		emit = 1'b0; err = 1'b0; st = STATUS_BAD;
		restart = 1'b0; nxt_discard = 1'b0;
		if (discard_q) begin
			restart = (b == 8'h0A);
		end else if (pos_q >= limit) begin
			err = 1'b1;
		end else if (saw_cr_q) begin
			if (b == 8'h0A) begin emit = 1'b1; st = STATUS_OK; restart = 1'b1; end
			else err = 1'b1;
		end else if (b == 8'h0A) begin
			err = 1'b1;
		end else begin
			case (stage_q)
				ST_METHOD: begin
					if (!(is_blank(b) && mcount_q == 3'd0)) begin
						if (b == 8'h20) err = !m_hit;
						else if (b < 8'h41 || b > 8'h5A || mcount_q >= 3'(MAX_METHOD)) err = 1'b1;
					end
				end
				ST_URL_GAP: err = !(is_blank(b) || b == 8'h68 || b == 8'h48 || b == 8'h2F);
				ST_SCHEME: begin
					if (sub_q == 3'd0)
						err = !(b == 8'h3A || is_alnum(b) || b == 8'h2D || b == 8'h2B || b == 8'h2E);
					else err = (b != 8'h2F);
				end
				ST_HOST: begin
					if (b == 8'h3A || b == 8'h2F || b == 8'h20) err = (b == 8'h20 && pos_q == host_off_q);
					else err = !(is_alnum(b) || b == 8'h2D || b == 8'h2E);
				end
				ST_PORT: begin
					if (b == 8'h2F || b == 8'h20) err = (b == 8'h20 && pos_q == port_off_q);
					else err = !is_digit(b);
				end
				ST_PATH: err = !(b == 8'h3F || b == 8'h20 || b == 8'h2E || path_char_ok(b));
				ST_QUERY: begin
					if (b == 8'h20) err = (pos_q == query_off_q);
					else err = !query_char_ok(b);
				end
				ST_VER_GAP, ST_VER_PREFIX: begin
					if (!(stage_q == ST_VER_GAP && is_blank(b))) begin
						if (stage_q == ST_VER_GAP) err = (lc != ver_char(3'd0));
						else err = (sub_q > 3'd4 || lc != ver_char(sub_q));
					end
				end
				ST_VER_MAJOR: err = !(is_digit(b) || (b == 8'h2E && sub_q == 3'd1));
				ST_VER_MINOR: begin
					if (is_digit(b)) err = 1'b0;
					else if (b == 8'h0D && sub_q == 3'd1) begin
						if (major_q != 4'd1 || minor_q > 4'd1) begin
							err = 1'b1; st = STATUS_VERSION;
						end
					end else err = 1'b1;
				end
				default: err = 1'b1;
			endcase
		end
		if (err) begin
			emit = 1'b1; restart = 1'b1; nxt_discard = (b != 8'h0A);
		end
	end

	// result word
	result_t r;
	logic [LEN_W-1:0] pl, pe;
	always_comb begin
		r = '0;
		r.status = st;
		if (!err) begin
			r.method = mcode_q; r.version_minor = minor_q[0];
			r.host_offset = host_off_q; r.host_len = host_len_q;
			r.port_offset = port_off_q; r.port_len = port_len_q;
			r.path_offset = path_off_q; r.path_len = path_len_q; r.ext_len = ext_q;
			r.query_offset = query_off_q; r.query_len = query_len_q;
		end
	end
	assign pl = pos_q - path_off_q;
	assign pe = (ext_q != '0) ? pos_q - ext_q : '0;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_len_q <= MAX_LINE;
		else if (cfg_we) max_len_q <= cfg_wdata;
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_METHOD; pos_q <= '0; mchars_q <= '0; mcount_q <= '0;
			mcode_q <= '0; sub_q <= '0; major_q <= '0; minor_q <= '0;
			host_off_q <= '0; host_len_q <= '0; port_off_q <= '0; port_len_q <= '0;
			path_off_q <= '0; path_len_q <= '0; ext_q <= '0;
			query_off_q <= '0; query_len_q <= '0; saw_cr_q <= 1'b0; discard_q <= 1'b0;
		end else if (take) begin
			if (restart) begin
				stage_q <= ST_METHOD; pos_q <= '0; mchars_q <= '0; mcount_q <= '0;
				mcode_q <= '0; sub_q <= '0; major_q <= '0; minor_q <= '0;
				host_off_q <= '0; host_len_q <= '0; port_off_q <= '0; port_len_q <= '0;
				path_off_q <= '0; path_len_q <= '0; ext_q <= '0;
				query_off_q <= '0; query_len_q <= '0; saw_cr_q <= 1'b0;
				discard_q <= nxt_discard;
			end else if (!discard_q) begin
				pos_q <= pos1;
				case (stage_q)
					ST_METHOD: begin
						if (!(is_blank(b) && mcount_q == 3'd0)) begin
							if (b == 8'h20) begin mcode_q <= m_code; stage_q <= ST_URL_GAP; end
							else begin
								mchars_q[8*mcount_q +: 8] <= b;
								mcount_q <= mcount_q + 1'b1;
							end
						end
					end
					ST_URL_GAP: begin
						if (b == 8'h68 || b == 8'h48) begin stage_q <= ST_SCHEME; sub_q <= '0; end
						else if (b == 8'h2F) begin path_off_q <= pos1; stage_q <= ST_PATH; end
					end
					ST_SCHEME: begin
						if (sub_q == 3'd0) begin
							if (b == 8'h3A) sub_q <= 3'd1;
						end else if (sub_q == 3'd1) sub_q <= 3'd2;
						else begin host_off_q <= pos1; stage_q <= ST_HOST; sub_q <= '0; end
					end
					ST_HOST: begin
						if (b == 8'h3A || b == 8'h2F || b == 8'h20) begin
							host_len_q <= pos_q - host_off_q;
							if (b == 8'h3A) begin port_off_q <= pos1; stage_q <= ST_PORT; end
							else if (b == 8'h2F) begin path_off_q <= pos1; stage_q <= ST_PATH; end
							else stage_q <= ST_VER_GAP;
						end
					end
					ST_PORT: begin
						if (b == 8'h2F || b == 8'h20) begin
							port_len_q <= pos_q - port_off_q;
							if (b == 8'h2F) begin path_off_q <= pos1; stage_q <= ST_PATH; end
							else stage_q <= ST_VER_GAP;
						end
					end
					ST_PATH: begin
						if (b == 8'h3F || b == 8'h20) begin
							path_len_q <= pl; ext_q <= pe;
							if (b == 8'h3F) begin query_off_q <= pos1; stage_q <= ST_QUERY; end
							else stage_q <= ST_VER_GAP;
						end else if (b == 8'h2E) ext_q <= pos1;
					end
					ST_QUERY: begin
						if (b == 8'h20) begin
							query_len_q <= pos_q - query_off_q; stage_q <= ST_VER_GAP;
						end
					end
					ST_VER_GAP: begin
						if (!is_blank(b)) begin stage_q <= ST_VER_PREFIX; sub_q <= 3'd1; end
					end
					ST_VER_PREFIX: begin
						if (sub_q == 3'd4) begin stage_q <= ST_VER_MAJOR; sub_q <= '0; end
						else sub_q <= sub_q + 1'b1;
					end
					ST_VER_MAJOR: begin
						if (is_digit(b)) begin major_q <= sat_acc(major_q, b); sub_q <= 3'd1; end
						else begin stage_q <= ST_VER_MINOR; sub_q <= '0; end
					end
					ST_VER_MINOR: begin
						if (is_digit(b)) begin minor_q <= sat_acc(minor_q, b); sub_q <= 3'd1; end
						else saw_cr_q <= 1'b1;
					end
					default: stage_q <= ST_METHOD;
				endcase
			end
		end
	end

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0; skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || res.ready) begin
				if (skid_vld_q) begin
					out_vld_q <= 1'b1; skid_vld_q <= 1'b0;
				end else out_vld_q <= take && emit;
			end else if (take && emit) skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || res.ready) begin
			if (skid_vld_q) out_q <= skid_q;
			else out_q <= r;
		end else if (take && emit) skid_q <= r;
	end

	assign res.valid = out_vld_q;
	assign res.data  = out_q;
endmodule
`default_nettype wire
